// ===== sv/box_circle_contact_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BOX_CIRCLE_CONTACT_CORE_DEFINES_SVH
`define BOX_CIRCLE_CONTACT_CORE_DEFINES_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define BCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define BCC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bcc_pkg.sv =====
package bcc_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DIM_WIDTH   = COORD_WIDTH - 2;
  localparam int NORM_WIDTH  = 16;

  // Pipeline stage positions.
  localparam int ST_OFFSET  = 0;
  localparam int ST_CLAMP   = 1;
  localparam int ST_DIFF    = 2;
  localparam int ST_ABS     = 3;
  localparam int ST_SQUARE  = 4;
  localparam int ST_SUM     = 5;
  localparam int ST_LOAD    = 6;
  localparam int ST_SQRT0   = 7;
  localparam int SQRT_STEPS = 4;
  localparam int ST_PREP    = 15;
  localparam int ST_DIV0    = 16;
  localparam int DIV_STEPS  = 3;
  localparam int ST_OUT     = 21;
  localparam int NUM_STAGES = 22;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] box_x;
    logic signed [COORD_WIDTH-1:0] box_y;
    logic        [DIM_WIDTH-1:0]   box_width;
    logic        [DIM_WIDTH-1:0]   box_height;
    logic signed [COORD_WIDTH-1:0] circle_cx;
    logic signed [COORD_WIDTH-1:0] circle_cy;
    logic        [DIM_WIDTH-1:0]   circle_diameter;
  } pair_t;

  typedef struct packed {
    logic                          hit;
    logic signed [NORM_WIDTH-1:0]  normal_x;
    logic signed [NORM_WIDTH-1:0]  normal_y;
    logic signed [COORD_WIDTH-1:0] penetration;
  } result_t;

  // Digit-recurrence square root working set, two operand bits per step.
  typedef struct packed {
    logic [63:0] op;
    logic [31:0] rt;
    logic [34:0] rm;
  } root_t;

  typedef struct packed {
    logic signed [26:0] nx;
    logic signed [26:0] ny;
    logic [21:0]        ex;
    logic [21:0]        ey;
    logic [21:0]        dia;
    logic signed [26:0] kx;
    logic signed [26:0] ky;
    logic               in_box;
    logic signed [26:0] vx;
    logic signed [26:0] vy;
    logic               negx;
    logic               negy;
    logic [22:0]        avx;
    logic [22:0]        avy;
    logic               rej;
    logic [14:0]        sx;
    logic [14:0]        sy;
    logic [45:0]        px;
    logic [45:0]        py;
    logic [43:0]        dd;
    logic [46:0]        sq;
    logic [29:0]        qx2;
    logic [29:0]        qy2;
    root_t              r1;
    root_t              r2;
    logic               zero;
    logic [23:0]        pen;
    logic [45:0]        rx;
    logic [45:0]        ry;
    logic [14:0]        qx;
    logic [14:0]        qy;
    result_t            res;
  } stage_t;

endpackage

// ===== sv/box_circle_contact_core.sv =====
// Box versus circle contact core. Each item is one axis-aligned box (top-left
// corner, width, height, Q16.8) and one circle (center, diameter); each item
// gives exactly one result: a hit flag, a Q2.14 unit contact normal pointing
// from the box toward the circle (flipped when the center lies inside the
// box) and the penetration depth, radius minus distance, in Q16.8. Misses
// report all fields zero; a zero distance reports a zero normal. The core is
// a 22-stage pipeline that takes one item per clock while the output side
// does not stall, and shows each result from its last stage register. Most
// stages go to the two 32-step square roots (four steps per stage) feeding a
// 15-step restoring divide (three steps per stage). Every stage has its own
// valid bit and a stalled output lets upstream bubbles fill, so a held
// result does not block accepting new items until the pipeline is full.
module box_circle_contact_core
  import bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    pair_valid,
  output logic    pair_ready,
  input  pair_t   pair,
  output logic    contact_valid,
  input  logic    contact_ready,
  output result_t contact
);

  stage_t                  pipe      [NUM_STAGES];
  stage_t                  pipe_next [NUM_STAGES];
  logic [NUM_STAGES-1:0]   valid;
  logic [NUM_STAGES-1:0]   ready;

  function automatic root_t sqrt_step(input root_t a);
    root_t       b;
    logic [34:0] r2;
    logic [34:0] tr;
    logic        ge;
    r2   = {a.rm[32:0], a.op[63:62]};
    tr   = {1'b0, a.rt, 2'b01};
    ge   = (r2 >= tr);
    b.rm = ge ? (r2 - tr) : r2;
    b.rt = {a.rt[30:0], ge};
    b.op = {a.op[61:0], 2'b00};
    return b;
  endfunction

  // First stage: center offset from box center in half-LSB units.
  function automatic stage_t stage_first(input pair_t in);
    stage_t s;
    s     = '0;
    s.nx  = {{2{in.circle_cx[23]}}, in.circle_cx, 1'b0}
          - {{2{in.box_x[23]}}, in.box_x, 1'b0} - {5'b0, in.box_width};
    s.ny  = {{2{in.circle_cy[23]}}, in.circle_cy, 1'b0}
          - {{2{in.box_y[23]}}, in.box_y, 1'b0} - {5'b0, in.box_height};
    s.ex  = in.box_width;
    s.ey  = in.box_height;
    s.dia = in.circle_diameter;
    return s;
  endfunction

  function automatic stage_t stage_step(input int k, input stage_t p);
    stage_t             s;
    logic signed [26:0] ax;
    logic signed [26:0] ay;
    logic signed [26:0] exs;
    logic signed [26:0] eys;
    logic [26:0]        avxf;
    logic [26:0]        avyf;
    logic [22:0]        t;
    logic [3:0]         sh;
    logic [3:0]         idx;
    logic [46:0]        dsh;
    logic [30:0]        s2;
    logic [24:0]        diff;
    logic [14:0]        qlx;
    logic [14:0]        qly;
    logic [15:0]        magx;
    logic [15:0]        magy;
    s    = p;
    exs  = {5'b0, p.ex};
    eys  = {5'b0, p.ey};
    if (k == ST_CLAMP) begin
      ax       = p.nx[26] ? -p.nx : p.nx;
      ay       = p.ny[26] ? -p.ny : p.ny;
      s.in_box = (ax <= exs) && (ay <= eys);
      if (p.nx > exs) s.kx = exs;
      else if (p.nx < -exs) s.kx = -exs;
      else s.kx = p.nx;
      if (p.ny > eys) s.ky = eys;
      else if (p.ny < -eys) s.ky = -eys;
      else s.ky = p.ny;
      // Snap an inside center to the x face when its x offset is larger, else to the y face; ties take the y face.
      if (s.in_box) begin
        if (ax > ay) s.kx = (p.nx > 0) ? exs : -exs;
        else s.ky = (p.ny > 0) ? eys : -eys;
      end
    end else if (k == ST_DIFF) begin
      s.vx   = p.nx - p.kx;
      s.vy   = p.ny - p.ky;
      s.negx = s.vx[26] != p.in_box;
      s.negy = s.vy[26] != p.in_box;
    end else if (k == ST_ABS) begin
      avxf  = p.vx[26] ? 27'(-p.vx) : 27'(p.vx);
      avyf  = p.vy[26] ? 27'(-p.vy) : 27'(p.vy);
      s.rej = !p.in_box && ((avxf > {5'b0, p.dia}) || (avyf > {5'b0, p.dia}));
      // Any hit keeps both magnitudes below 2^23.
      s.avx = avxf[22:0];
      s.avy = avyf[22:0];
    end else if (k == ST_SQUARE) begin
      s.px = {23'b0, p.avx} * {23'b0, p.avx};
      s.py = {23'b0, p.avy} * {23'b0, p.avy};
      s.dd = {22'b0, p.dia} * {22'b0, p.dia};
      t    = p.avx | p.avy;
      sh   = 4'd8;
      for (int i = 8; i >= 0; i--) begin
        if ((t >> i) < 23'd32768) sh = 4'(i);
      end
      s.sx = 15'(p.avx >> sh);
      s.sy = 15'(p.avy >> sh);
    end else if (k == ST_SUM) begin
      s.sq  = {1'b0, p.px} + {1'b0, p.py};
      if (!p.in_box && (s.sq > {3'b0, p.dd})) s.rej = 1'b1;
      s.qx2 = {15'b0, p.sx} * {15'b0, p.sx};
      s.qy2 = {15'b0, p.sy} * {15'b0, p.sy};
    end else if (k == ST_LOAD) begin
      s2      = {1'b0, p.qx2} + {1'b0, p.qy2};
      s.r1.op = {17'b0, p.sq};
      s.r1.rt = '0;
      s.r1.rm = '0;
      s.r2.op = {1'b0, s2, 32'b0};
      s.r2.rt = '0;
      s.r2.rm = '0;
    end else if ((k >= ST_SQRT0) && (k < ST_PREP)) begin
      for (int i = 0; i < SQRT_STEPS; i++) begin
        s.r1 = sqrt_step(s.r1);
        s.r2 = sqrt_step(s.r2);
      end
    end else if (k == ST_PREP) begin
      diff   = {3'b0, p.dia} - {1'b0, p.r1.rt[23:0]};
      s.pen  = diff[24:1];
      s.zero = (p.sq == '0);
      s.rx   = {1'b0, p.sx, 30'b0} + {15'b0, p.r2.rt[31:1]};
      s.ry   = {1'b0, p.sy, 30'b0} + {15'b0, p.r2.rt[31:1]};
      s.qx   = '0;
      s.qy   = '0;
    end else if ((k >= ST_DIV0) && (k < ST_OUT)) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        idx = 4'(14 - DIV_STEPS * (k - ST_DIV0) - i);
        dsh = {15'b0, p.r2.rt} << idx;
        if ({1'b0, s.rx} >= dsh) begin
          s.rx      = s.rx - dsh[45:0];
          s.qx[idx] = 1'b1;
        end
        if ({1'b0, s.ry} >= dsh) begin
          s.ry      = s.ry - dsh[45:0];
          s.qy[idx] = 1'b1;
        end
      end
    end else if (k == ST_OUT) begin
      qlx  = (p.qx > 15'd16384) ? 15'd16384 : p.qx;
      qly  = (p.qy > 15'd16384) ? 15'd16384 : p.qy;
      magx = p.zero ? 16'd0 : {1'b0, qlx};
      magy = p.zero ? 16'd0 : {1'b0, qly};
      s.res.hit         = 1'b1;
      s.res.normal_x    = p.negx ? -magx : magx;
      s.res.normal_y    = p.negy ? -magy : magy;
      s.res.penetration = p.pen;
      if (p.rej) s.res = '0;
    end
    return s;
  endfunction

  // Stage k loads whenever it is empty or its successor moves.
  always_comb begin
    ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || contact_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_comb begin
    pipe_next[0] = stage_first(pair);
    for (int k = 1; k < NUM_STAGES; k++) begin
      pipe_next[k] = stage_step(k, pipe[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) valid[0] <= pair_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) valid[k] <= valid[k-1];
      end
    end
  end

  // Payload advances with its valid bit; hold while stalled.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (ready[k]) pipe[k] <= pipe_next[k];
    end
  end

  assign pair_ready    = ready[0];
  assign contact_valid = valid[NUM_STAGES-1];
  assign contact       = pipe[NUM_STAGES-1].res;

endmodule

// ===== sv/bcc_checker.sv =====
`include "box_circle_contact_core_defines.svh"

module bcc_checker
  import bcc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    pair_valid,
  input logic    pair_ready,
  input pair_t   pair,
  input logic    contact_valid,
  input logic    contact_ready,
  input result_t contact
);

  `BCC_ASSERT_RST(a_rst_empty, rst |=> !contact_valid, "result valid right after reset")

  `BCC_ASSERT(a_miss_zero, contact_valid && !contact.hit |-> contact.normal_x == 0 && contact.normal_y == 0 && contact.penetration == 0, "miss with nonzero fields")

  `BCC_ASSERT(a_norm_range, contact_valid |-> contact.normal_x <= 16384 && contact.normal_x >= -16384 && contact.normal_y <= 16384 && contact.normal_y >= -16384, "normal out of range")

  `BCC_ASSERT(a_hold, contact_valid && !contact_ready |=> contact_valid && $stable(contact), "stalled result changed")

endmodule

bind box_circle_contact_core bcc_checker u_bcc_checker (.*);
